>>> hdl/second_order_lowpass_biquad_defines.svh
// assertion macros for the biquad low-pass filter and its checker
// no dependencies; each macro expects clk and rst_n in scope
`ifndef SECOND_ORDER_LOWPASS_BIQUAD_DEFINES_SVH
`define SECOND_ORDER_LOWPASS_BIQUAD_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define BQD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad check failed");

// next-cycle implication, ignored while in reset
`define BQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad check failed");

// next-cycle implication that also holds across reset
`define BQD_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("biquad check failed");

`endif

>>> hdl/bqd_pkg.sv
// shared types and constants for the biquad low-pass filter
// no dependencies
package bqd_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int COEF_BITS          = 32;
  localparam int CFG_IDX_BITS       = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_BITS-1:0] B0_RST = 32'sd268435456;
  localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

endpackage

>>> hdl/bqd_coef_regs.sv
// coefficient register file, written through the plain config port
// depends on bqd_pkg
module bqd_coef_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bqd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bqd_pkg::COEF_BITS-1:0]     cfg_wdata,
  output bqd_pkg::coef_set_t                coefs
);
  import bqd_pkg::*;

  coef_set_t coef_r;
  coef_set_t coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_B0:  coef_nxt.b0 = cfg_wdata;
        REG_B1:  coef_nxt.b1 = cfg_wdata;
        REG_B2:  coef_nxt.b2 = cfg_wdata;
        REG_A1:  coef_nxt.a1 = cfg_wdata;
        REG_A2:  coef_nxt.a2 = cfg_wdata;
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= B0_RST;
      coef_r.b1 <= COEF_ZERO;
      coef_r.b2 <= COEF_ZERO;
      coef_r.a1 <= COEF_ZERO;
      coef_r.a2 <= COEF_ZERO;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coefs = coef_r;

endmodule

>>> hdl/bqd_core.sv
// direct form I arithmetic: five products, exact sum, round half up, saturate
// holds the input and output history; depends on bqd_pkg
module bqd_core #(
  parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic signed [SAMPLE_BITS-1:0]  x,
  input  bqd_pkg::coef_set_t             coefs,
  output logic signed [SAMPLE_BITS-1:0]  y,
  output logic                           clip
);
  import bqd_pkg::*;

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int Q_W    = ACC_W - COEF_FRAC_BITS;
  localparam int HI_W   = Q_W - SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] prev_in_r, prev_in2_r, prev_out_r, prev_out2_r;

  logic signed [COEF_BITS-1:0] c_b0, c_b1, c_b2, c_a1, c_a2;
  logic signed [PROD_W-1:0]    p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]     half_c;
  logic signed [ACC_W-1:0]     acc;
  logic        [Q_W-1:0]       q;
  logic        [HI_W-1:0]      q_hi;
  logic                        in_range;

  assign c_b0 = coefs.b0;
  assign c_b1 = coefs.b1;
  assign c_b2 = coefs.b2;
  assign c_a1 = coefs.a1;
  assign c_a2 = coefs.a2;

  assign p_b0 = c_b0 * x;
  assign p_b1 = c_b1 * prev_in_r;
  assign p_b2 = c_b2 * prev_in2_r;
  assign p_a1 = c_a1 * prev_out_r;
  assign p_a2 = c_a2 * prev_out2_r;

  assign half_c = {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2) + half_c;

  // floor shift, then saturate when the upper bits are not all sign
  assign q        = acc[ACC_W-1:COEF_FRAC_BITS];
  assign q_hi     = q[Q_W-1:SAMPLE_BITS-1];
  assign in_range = (&q_hi) | ~(|q_hi);

  always_comb begin
    if (in_range) begin
      y = q[SAMPLE_BITS-1:0];
    end else if (q[Q_W-1]) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign clip = ~in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_r   <= '0;
      prev_in2_r  <= '0;
      prev_out_r  <= '0;
      prev_out2_r <= '0;
    end else if (step) begin
      prev_in2_r  <= prev_in_r;
      prev_in_r   <= x;
      prev_out2_r <= prev_out_r;
      prev_out_r  <= y;
    end
  end

endmodule

>>> hdl/second_order_lowpass_biquad.sv
// second-order low-pass biquad, direct form I, one item per cycle while the output is not stalled
// an accepted item passes the input register, then the result register, before out_tvalid rises
// throughput: 1 item per cycle while out_tready holds; the product-sum-saturate path closing on prev_out sets it
// reset: synchronous active-low; history clears to zero, b0 to 1.0, other coefficients to 0
// depends on bqd_pkg, bqd_coef_regs, bqd_core
module second_order_lowpass_biquad #(
  parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
  parameter int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [TDATA_W-1:0]                in_tdata,   // sample_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [TDATA_W-1:0]                out_tdata,  // sample_out
  output logic                              out_tuser,  // clipped
  input  logic                              cfg_wr_en,
  input  logic [bqd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bqd_pkg::COEF_BITS-1:0]     cfg_wdata
);
  import bqd_pkg::*;

  coef_set_t coefs;

  logic                          stg_vld_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          out_vld_r;
  logic        [SAMPLE_BITS-1:0] y_r;
  logic                          clip_r;
  logic signed [SAMPLE_BITS-1:0] y_calc;
  logic                          clip_calc;
  logic                          advance;
  logic                          stage_go;
  logic                          in_acc;

  bqd_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coefs     (coefs)
  );

  bqd_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (stage_go),
    .x     (x_r),
    .coefs (coefs),
    .y     (y_calc),
    .clip  (clip_calc)
  );

  assign advance   = ~out_vld_r | out_tready;
  assign stage_go  = stg_vld_r & advance;
  assign in_tready = ~stg_vld_r | advance;
  assign in_acc    = in_tvalid & in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_acc) begin
      stg_vld_r <= 1'b1;
    end else if (stage_go) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_tdata[SAMPLE_BITS-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      y_r    <= y_calc;
      clip_r <= clip_calc;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = TDATA_W'(y_r);
  assign out_tuser  = clip_r;

endmodule

>>> hdl/bqd_checker.sv
// port-level checker for the biquad filter, bound to the top level
// depends on bqd_pkg and second_order_lowpass_biquad_defines.svh
`include "second_order_lowpass_biquad_defines.svh"

module bqd_checker #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,  // sample_out
  input logic               out_tuser   // clipped
);
  import bqd_pkg::*;

  // no result straight out of reset
  `BQD_ASSERT_ALWAYS(a_rst_quiet, !rst_n, !out_tvalid)

  // a draining output never holds back the input side
  `BQD_ASSERT_NOW(a_ready_follows, out_tready, in_tready)

  // an item accepted with the output draining passes the input and result registers to out_tvalid
  `BQD_ASSERT_NEXT(a_latency, (in_tvalid && in_tready) ##1 out_tready, out_tvalid)

  // a stalled result holds its value and flag
  `BQD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind second_order_lowpass_biquad bqd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .TDATA_W     (TDATA_W)
) u_bqd_checker (.*);
